// File: hw/rtl/gf32ta_pkg.sv
`timescale 1ns / 1ps

package gf32ta_pkg;

    // GF(256) reduction term of x^8+x^4+x^3+x+1 and the tower constant.
    localparam logic [7:0] GF8_REDUCE  = 8'h1B;
    localparam logic [7:0] TOWER_CONST = 8'h20;

    // Number of byte products in one Karatsuba GF(2^32) multiply.
    localparam int unsigned NUM_PROD = 9;
    localparam int unsigned NUM_SUB  = 3;

    typedef enum logic [1:0] {
        OP_MUL   = 2'd0,
        OP_ADD   = 2'd1,
        OP_SCALE = 2'd2,
        OP_CMP   = 2'd3
    } op_t;

    // Request and response payloads.
    typedef struct packed {
        op_t         opcode;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [7:0]  scalar;
    } req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        equal;
    } rsp_t;

    // Stage one: nine byte products, plus the result of the simple opcodes.
    typedef struct packed {
        op_t                          opcode;
        logic [NUM_PROD-1:0][7:0]     prod;
        logic [31:0]                  alt;
        logic                         equal;
    } prod_stage_t;

    // Stage two: the three GF(2^16) products (low, high, middle).
    typedef struct packed {
        op_t                          opcode;
        logic [NUM_SUB-1:0][15:0]     p16;
        logic [31:0]                  alt;
        logic                         equal;
    } fold_stage_t;

    // Shift-and-add GF(256) multiply, most significant bit of b first.
    function automatic logic [7:0] gf8_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic       hi;
        r = '0;
        for (int i = 7; i >= 0; i--) begin
            hi = r[7];
            r  = {r[6:0], 1'b0};
            if (hi) begin
                r = r ^ GF8_REDUCE;
            end
            if (b[i]) begin
                r = r ^ a;
            end
        end
        return r;
    endfunction

    // Multiplication by the tower constant; a fixed XOR network after synthesis.
    function automatic logic [7:0] gf8_mul_tc(input logic [7:0] a);
        return gf8_mul(a, TOWER_CONST);
    endfunction

endpackage

// File: hw/rtl/gf32ta_prod.sv
`timescale 1ns / 1ps

module gf32ta_prod (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  gf32ta_pkg::req_t         in_req,
    output logic                     out_valid,
    input  logic                     out_ready,
    output gf32ta_pkg::prod_stage_t  out_data
);
    import gf32ta_pkg::*;

    logic        valid_reg;
    prod_stage_t data_reg;
    prod_stage_t data_next;

    // Stage advances when empty or when the next stage takes its contents.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Byte products of the low, high and middle GF(2^16) halves, and the
    // results of the opcodes that need no further work.
    always_comb begin
        logic [NUM_SUB-1:0][15:0] x16;
        logic [NUM_SUB-1:0][15:0] y16;
        x16[0] = in_req.operand_a[15:0];
        x16[1] = in_req.operand_a[31:16];
        x16[2] = in_req.operand_a[15:0] ^ in_req.operand_a[31:16];
        y16[0] = in_req.operand_b[15:0];
        y16[1] = in_req.operand_b[31:16];
        y16[2] = in_req.operand_b[15:0] ^ in_req.operand_b[31:16];

        data_next.opcode = in_req.opcode;
        for (int g = 0; g < NUM_SUB; g++) begin
            data_next.prod[3*g]   = gf8_mul(x16[g][15:8], y16[g][15:8]);
            data_next.prod[3*g+1] = gf8_mul(x16[g][7:0], y16[g][7:0]);
            data_next.prod[3*g+2] = gf8_mul(x16[g][7:0] ^ x16[g][15:8],
                                            y16[g][7:0] ^ y16[g][15:8]);
        end

        data_next.alt   = '0;
        data_next.equal = 1'b0;
        case (in_req.opcode)
            OP_ADD: begin
                data_next.alt = in_req.operand_a ^ in_req.operand_b;
            end
            OP_SCALE: begin
                for (int k = 0; k < 4; k++) begin
                    data_next.alt[8*k +: 8] = gf8_mul(in_req.scalar,
                                                      in_req.operand_b[8*k +: 8]);
                end
            end
            OP_CMP: begin
                data_next.equal = (in_req.operand_a == in_req.operand_b);
            end
            default: begin
                data_next.alt = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/gf32ta_fold.sv
`timescale 1ns / 1ps

module gf32ta_fold (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  gf32ta_pkg::prod_stage_t  in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output gf32ta_pkg::fold_stage_t  out_data
);
    import gf32ta_pkg::*;

    logic        valid_reg;
    fold_stage_t data_reg;
    fold_stage_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Reduce each GF(2^16) product by X^2 = X + tower constant.
    always_comb begin
        data_next.opcode = in_data.opcode;
        data_next.alt    = in_data.alt;
        data_next.equal  = in_data.equal;
        for (int g = 0; g < NUM_SUB; g++) begin
            data_next.p16[g][7:0]  = in_data.prod[3*g+1] ^ gf8_mul_tc(in_data.prod[3*g]);
            data_next.p16[g][15:8] = in_data.prod[3*g+2] ^ in_data.prod[3*g+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/gf32ta_fin.sv
`timescale 1ns / 1ps

module gf32ta_fin (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  gf32ta_pkg::fold_stage_t  in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output gf32ta_pkg::rsp_t         out_rsp
);
    import gf32ta_pkg::*;

    logic  valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_rsp   = rsp_reg;

    // Top-level reduction by Y^2 = Y + c, where c is the tower constant times X.
    always_comb begin
        logic [15:0] hh;
        logic [15:0] ll;
        logic [15:0] mm;
        logic [15:0] hh_c;
        hh = in_data.p16[1];
        ll = in_data.p16[0];
        mm = in_data.p16[2];
        hh_c[7:0]  = gf8_mul_tc(gf8_mul_tc(hh[15:8]));
        hh_c[15:8] = gf8_mul_tc(hh[7:0] ^ hh[15:8]);

        rsp_next.equal = in_data.equal;
        if (in_data.opcode == OP_MUL) begin
            rsp_next.value = {mm ^ ll, hh_c ^ ll};
        end else begin
            rsp_next.value = in_data.alt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// File: hw/rtl/gf32_32_tower_field_alu_core.sv
`timescale 1ns / 1ps

// File: hw/rtl/gf2_32_tower_field_alu_core.sv
`timescale 1ns / 1ps

// Channel   Ports                      Payload
// request   s_valid, s_ready, s_req    opcode, operand_a, operand_b, scalar
// response  m_valid, m_ready, m_rsp    value, equal
//
// Every opcode passes three register stages from request to response: byte products,
// GF(2^16) reduction, and the final GF(2^32) reduction each own a register stage.
// A new request is accepted every cycle while the response side keeps up.
// Reset clears the stage valid bits only; data registers are not reset.
// A stall fills empty stages first and then holds each stage in place.

module gf2_32_tower_field_alu_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gf32ta_pkg::req_t  s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output gf32ta_pkg::rsp_t  m_rsp
);
    import gf32ta_pkg::*;

    logic        p_valid;
    logic        p_ready;
    prod_stage_t p_data;
    logic        f_valid;
    logic        f_ready;
    fold_stage_t f_data;

    // Byte products.
    gf32ta_prod u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (s_req),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_data  (p_data)
    );

    // GF(2^16) reduction.
    gf32ta_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_data   (p_data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    // GF(2^32) reduction and response register.
    gf32ta_fin u_fin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rsp   (m_rsp)
    );

    // A compare never carries a nonzero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.equal |-> m_rsp.value == '0)
        else $error("compare response carries a nonzero value");

    // An accepting response side lets the whole pipeline move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("request stalled while the response side accepts");

    // An empty response stage never blocks the request side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request stalled with an empty response stage");

    // An accepted request reaches the response register when the response side does not stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("request lost in the pipeline");

endmodule

// File: dv/gf2_32_tower_field_alu_core_tb.sv
`timescale 1ns / 1ps

module gf2_32_tower_field_alu_core_tb;

    import gf32ta_pkg::*;

    localparam int unsigned RANDOM_PER_PHASE = 140;
    localparam int unsigned BACKLOG_HOLD     = 200;
    localparam int unsigned DRAIN_CYCLES     = 10;
    localparam int unsigned NUM_DIRECTED     = 20;

    // Traffic shapes applied by the request and response sides.
    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SEND_GAPS,
        TRAFFIC_RECV_STALLS,
        TRAFFIC_BOTH,
        TRAFFIC_BACKLOG
    } traffic_t;

    // One directed request, with its response where it is obvious by inspection.
    typedef struct packed {
        op_t         op;
        logic [31:0] a;
        logic [31:0] b;
        logic [7:0]  s;
        logic        typed;
        logic [31:0] value;
        logic        equal;
    } dir_row_t;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{OP_MUL,   32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_MUL,   32'hFFFF_FFFF, 32'h0000_0001, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_MUL,   32'h0000_0001, 32'h1234_5678, 8'h00, 1'b1, 32'h1234_5678, 1'b0},
        '{OP_MUL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_MUL,   32'h0001_0000, 32'h0001_0000, 8'h00, 1'b1, 32'h0001_2000, 1'b0},
        '{OP_MUL,   32'h0000_0100, 32'h0000_0100, 8'h00, 1'b1, 32'h0000_0120, 1'b0},
        '{OP_MUL,   32'h0000_0080, 32'h0000_0002, 8'h00, 1'b1, 32'h0000_001B, 1'b0},
        '{OP_MUL,   32'h8000_0000, 32'h8000_0000, 8'hFF, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_ADD,   32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_ADD,   32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_SCALE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_SCALE, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 8'h01, 1'b1, 32'hDEAD_BEEF, 1'b0},
        '{OP_SCALE, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_SCALE, 32'h1234_5678, 32'h8080_8080, 8'h02, 1'b1, 32'h1B1B_1B1B, 1'b0},
        '{OP_CMP,   32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1, 32'h0000_0000, 1'b1},
        '{OP_CMP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'h0000_0000, 1'b1},
        '{OP_CMP,   32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'h00, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_CMP,   32'h0000_0000, 32'h8000_0000, 8'h00, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_MUL,   32'hC3A5_0F71, 32'h9E37_79B9, 8'hFF, 1'b0, 32'h0000_0000, 1'b0}
    };

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    req_t     s_req;
    logic     m_valid;
    logic     m_ready;
    rsp_t     m_rsp;

    rsp_t     pending_results[$];
    int       mismatch_cnt;
    traffic_t traffic;
    bit       backlog_done;

    gf2_32_tower_field_alu_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    // GF(256) product, reducing by x^8+x^4+x^3+x+1 while walking y from the top bit.
    function automatic logic [7:0] gf8_product(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        acc = '0;
        for (int i = 7; i >= 0; i--) begin
            acc = {acc[6:0], 1'b0} ^ ({8{acc[7]}} & GF8_REDUCE);
            if (y[i]) begin
                acc = acc ^ x;
            end
        end
        return acc;
    endfunction

    // GF(2^16) product modulo X^2+X+0x20.
    function automatic logic [15:0] gf16_product(input logic [15:0] x, input logic [15:0] y);
        logic [7:0] hh;
        logic [7:0] ll;
        logic [7:0] mid;
        hh  = gf8_product(x[15:8], y[15:8]);
        ll  = gf8_product(x[7:0], y[7:0]);
        mid = gf8_product(x[7:0] ^ x[15:8], y[7:0] ^ y[15:8]);
        return {mid ^ ll, ll ^ gf8_product(hh, TOWER_CONST)};
    endfunction

    // Product of a GF(2^16) element with the top-level constant 0x20*X.
    function automatic logic [15:0] gf16_times_c(input logic [15:0] x);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = gf8_product(gf8_product(x[15:8], TOWER_CONST), TOWER_CONST);
        hi = gf8_product(x[7:0] ^ x[15:8], TOWER_CONST);
        return {hi, lo};
    endfunction

    // GF(2^32) product modulo Y^2+Y+c, Karatsuba style over the two halves.
    function automatic logic [31:0] gf32_product(input logic [31:0] x, input logic [31:0] y);
        logic [15:0] hh;
        logic [15:0] ll;
        logic [15:0] mid;
        hh  = gf16_product(x[31:16], y[31:16]);
        ll  = gf16_product(x[15:0], y[15:0]);
        mid = gf16_product(x[15:0] ^ x[31:16], y[15:0] ^ y[31:16]);
        return {mid ^ ll, gf16_times_c(hh) ^ ll};
    endfunction

    // Expected response of the unit for one request.
    function automatic rsp_t alu_result(input req_t req);
        rsp_t rsp;
        rsp = '0;
        case (req.opcode)
            OP_MUL: begin
                rsp.value = gf32_product(req.operand_a, req.operand_b);
            end
            OP_ADD: begin
                rsp.value = req.operand_a ^ req.operand_b;
            end
            OP_SCALE: begin
                for (int k = 0; k < 4; k++) begin
                    rsp.value[8*k +: 8] = gf8_product(req.scalar, req.operand_b[8*k +: 8]);
                end
            end
            default: begin
                rsp.equal = (req.operand_a == req.operand_b);
            end
        endcase
        return rsp;
    endfunction

    // Operand mix: plenty of random words, plus zeros, ones, single bits and byte patterns.
    function automatic logic [31:0] pick_operand();
        logic [31:0] word;
        case ($urandom_range(9))
            0: word = '0;
            1: word = '1;
            2: word = 32'h1 << $urandom_range(31);
            3: word = 32'hFF << (8 * $urandom_range(3));
            4: word = {4{8'($urandom)}};
            default: word = $urandom;
        endcase
        return word;
    endfunction

    function automatic int send_gap_pct(input traffic_t t);
        case (t)
            TRAFFIC_SEND_GAPS: return 45;
            TRAFFIC_BOTH:      return 25;
            default:           return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input traffic_t t);
        case (t)
            TRAFFIC_RECV_STALLS: return 45;
            TRAFFIC_BOTH:        return 25;
            default:             return 0;
        endcase
    endfunction

    // Offer one request, holding it until accepted, then log its expected response.
    task automatic send_request(input req_t req, input logic typed, input rsp_t typed_rsp);
        int gap;
        gap = send_gap_pct(traffic);
        while (gap != 0 && $urandom_range(99) < gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.push_back(typed ? typed_rsp : alu_result(req));
    endtask

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Response side: random stalls, and one long hold-off in the backlog phase.
    initial begin
        int hold_cnt;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (traffic == TRAFFIC_BACKLOG && !backlog_done) begin
                m_ready  <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < BACKLOG_HOLD) begin
                    @(posedge aclk);
                    hold_cnt++;
                end
                backlog_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct(traffic));
            end
        end
    end

    // Response checker: every accepted response must match the oldest expectation.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response value=%h equal=%b",
                         $time, m_rsp.value, m_rsp.equal);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_rsp.value !== want.value) begin
                    $display("%0t: value mismatch expected %h actual %h",
                             $time, want.value, m_rsp.value);
                    mismatch_cnt++;
                end
                if (m_rsp.equal !== want.equal) begin
                    $display("%0t: equal mismatch expected %b actual %b",
                             $time, want.equal, m_rsp.equal);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, random phases, then drain.
    initial begin
        req_t req;
        rsp_t typed_rsp;
        mismatch_cnt = 0;
        backlog_done = 1'b0;
        traffic      = TRAFFIC_STEADY;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req        <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: extremes, each opcode and the ignored inputs.
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            req.opcode      = DIRECTED[i].op;
            req.operand_a   = DIRECTED[i].a;
            req.operand_b   = DIRECTED[i].b;
            req.scalar      = DIRECTED[i].s;
            typed_rsp.value = DIRECTED[i].value;
            typed_rsp.equal = DIRECTED[i].equal;
            send_request(req, DIRECTED[i].typed, typed_rsp);
        end

        // Random requests under each traffic shape in turn.
        for (int ph = TRAFFIC_STEADY; ph <= TRAFFIC_BACKLOG; ph++) begin
            traffic = traffic_t'(ph);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                req.opcode    = op_t'($urandom_range(3));
                req.operand_a = pick_operand();
                req.operand_b = pick_operand();
                req.scalar    = ($urandom_range(3) == 0) ? 8'($urandom_range(2)) : 8'($urandom);
                // Equal operands are rare at random; force them for half the compares.
                if (req.opcode == OP_CMP && $urandom_range(1) == 1) begin
                    req.operand_b = req.operand_a;
                end
                send_request(req, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        traffic = TRAFFIC_STEADY;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
